// File: rtl/core/xcpf_pkg.sv
`timescale 1ns / 1ps

package xcpf_pkg;

  // Largest payload that is framed; anything above is rejected.
  localparam logic [15:0] MaxPayload    = 16'd1024;
  localparam logic [7:0]  HeaderByte    = 8'hAA;
  localparam logic [7:0]  TrailerByte   = 8'h55;
  localparam logic [11:0] FrameOverhead = 12'd7;

  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    logic        op;
    logic [7:0]  frame_cmd;
    logic [10:0] payload_size;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       size_error;
  } out_item_t;

  localparam logic OpStart   = 1'b0;
  localparam logic OpPayload = 1'b1;

  typedef enum logic [1:0] {
    KindErr,
    KindHdr,
    KindData
  } kind_e;

  // One queued job for the back end. For data jobs only slot4 and the closing
  // fields are meaningful.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] cmd;
    logic [7:0] len_lo;
    logic [7:0] len_hi;
    logic [7:0] slot4;   // sequence number or payload byte
    logic       close;   // append checksum and trailer
    logic [7:0] chk;
  } job_t;

endpackage

// File: rtl/core/xcpf_front.sv
`timescale 1ns / 1ps

module xcpf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  xcpf_pkg::in_item_t in_item_i,
  input  logic              push_ready_i,
  output logic              push_o,
  output xcpf_pkg::job_t    push_job_o
);
  import xcpf_pkg::*;

  logic [7:0]  seq_q, seq_d;
  logic [7:0]  xor_q, xor_d;
  logic [10:0] rem_q, rem_d;
  logic        in_frame_q, in_frame_d;

  logic        accept;
  logic        oversize;
  logic [11:0] total;
  logic [7:0]  hdr_chk;
  logic [10:0] rem_dec;
  logic [7:0]  data_chk;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  assign oversize = 16'(in_item_i.payload_size) > MaxPayload;
  assign total    = {1'b0, in_item_i.payload_size} + FrameOverhead;
  assign hdr_chk  = in_item_i.frame_cmd ^ total[7:0] ^ {4'b0, total[11:8]} ^ seq_q;
  assign rem_dec  = rem_q - 11'd1;
  assign data_chk = xor_q ^ in_item_i.payload_byte;

  always_comb begin
    seq_d      = seq_q;
    xor_d      = xor_q;
    rem_d      = rem_q;
    in_frame_d = in_frame_q;
    push_o     = 1'b0;
    push_job_o = '{kind: KindErr, cmd: in_item_i.frame_cmd, len_lo: total[7:0],
                   len_hi: {4'b0, total[11:8]}, slot4: seq_q, close: 1'b0, chk: hdr_chk};
    if (accept) begin
      unique case (in_item_i.op)
        OpStart: begin
          // a start while a frame is open is ignored
          if (!in_frame_q) begin
            push_o = 1'b1;
            if (oversize) begin
              push_job_o.kind = KindErr;
            end else begin
              push_job_o.kind  = KindHdr;
              push_job_o.close = (in_item_i.payload_size == 11'd0);
              seq_d = seq_q + 8'd1;
              if (in_item_i.payload_size == 11'd0) begin
                xor_d = 8'd0;
              end else begin
                xor_d      = hdr_chk;
                rem_d      = in_item_i.payload_size;
                in_frame_d = 1'b1;
              end
            end
          end
        end
        OpPayload: begin
          if (in_frame_q) begin
            push_o           = 1'b1;
            push_job_o.kind  = KindData;
            push_job_o.slot4 = in_item_i.payload_byte;
            push_job_o.chk   = data_chk;
            push_job_o.close = (rem_dec == 11'd0);
            if (rem_dec == 11'd0) begin
              xor_d      = 8'd0;
              rem_d      = 11'd0;
              in_frame_d = 1'b0;
            end else begin
              xor_d = data_chk;
              rem_d = rem_dec;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= 8'd0;
      xor_q      <= 8'd0;
      rem_q      <= 11'd0;
      in_frame_q <= 1'b0;
    end else begin
      seq_q      <= seq_d;
      xor_q      <= xor_d;
      rem_q      <= rem_d;
      in_frame_q <= in_frame_d;
    end
  end

endmodule

// File: rtl/core/xcpf_queue.sv
`timescale 1ns / 1ps

module xcpf_queue #(
  parameter int unsigned Depth = xcpf_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  xcpf_pkg::job_t push_job_i,
  output logic           head_valid_o,
  input  logic           pop_i,
  output xcpf_pkg::job_t head_job_o
);
  import xcpf_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  Full     = CntW'(Depth);

  job_t             mem_q [Depth];
  logic [AddrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != Full);
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastAddr) ? '0 : wptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastAddr) ? '0 : rptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/core/xcpf_back.sv
`timescale 1ns / 1ps

module xcpf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  xcpf_pkg::job_t     head_job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output xcpf_pkg::out_item_t out_item_o
);
  import xcpf_pkg::*;

  logic [2:0] step_q;
  logic [2:0] slot;
  logic       advance;
  logic       last;
  out_item_t  cur;
  logic       out_valid_q;
  out_item_t  out_item_q;

  // data jobs enter the byte sequence at slot 4, where header jobs put the sequence number
  assign slot    = (head_job_i.kind == KindData) ? step_q + 3'd4 : step_q;
  assign advance = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    cur  = '{out_byte: 8'd0, frame_end: 1'b0, size_error: 1'b0};
    last = 1'b0;
    if (head_job_i.kind == KindErr) begin
      cur  = '{out_byte: 8'd0, frame_end: 1'b1, size_error: 1'b1};
      last = 1'b1;
    end else begin
      unique case (slot)
        3'd0: cur.out_byte = HeaderByte;
        3'd1: cur.out_byte = head_job_i.cmd;
        3'd2: cur.out_byte = head_job_i.len_lo;
        3'd3: cur.out_byte = head_job_i.len_hi;
        3'd4: cur.out_byte = head_job_i.slot4;
        3'd5: cur.out_byte = head_job_i.chk;
        3'd6: begin
          cur.out_byte  = TrailerByte;
          cur.frame_end = 1'b1;
        end
        default: cur.out_byte = 8'd0;
      endcase
      last = ((slot == 3'd4) && !head_job_i.close) || (slot == 3'd6);
    end
  end

  assign pop_o       = advance && last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        step_q      <= last ? 3'd0 : step_q + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/xor_checked_packet_framer_top.sv
`timescale 1ns / 1ps
// With queue and output empty, an item's first result byte is registered in the job queue
// and then in the output register before it is valid. Throughput: one result byte per
// cycle while out_ready_i is set, and payload items stream at one per cycle likewise. A
// start item occupies the output for 5 bytes (7 for an empty payload, 1 if oversized); a
// job queue of QueueDepth entries between classifier and byte sequencer absorbs these bursts.
// Reset clears the sequence number, checksum, frame state, job queue and output valid.
module xor_checked_packet_framer_top #(
  parameter int unsigned QueueDepth = xcpf_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xcpf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output xcpf_pkg::out_item_t out_item_o
);
  import xcpf_pkg::*;

  logic push, push_ready, head_valid, pop;
  job_t push_job, head_job;

  xcpf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_ready_i (push_ready),
    .push_o       (push),
    .push_job_o   (push_job)
  );

  xcpf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_job_o   (head_job)
  );

  xcpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

// File: sim/xor_checked_packet_framer_top_test.sv
`timescale 1ns / 1ps

module xor_checked_packet_framer_top_test;
  import xcpf_pkg::*;

  // Tracks the framer's state and holds the byte stream it should produce.
  class frame_byte_scoreboard;
    logic [7:0]  seq_num;
    logic [7:0]  xor_sum;
    logic [10:0] bytes_left;
    bit          in_frame;
    out_item_t   expected_bytes[$];
    int          fails;

    function new();
      seq_num    = '0;
      xor_sum    = '0;
      bytes_left = '0;
      in_frame   = 1'b0;
      fails      = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic last, logic err);
      out_item_t r;
      r.out_byte   = b;
      r.frame_end  = last;
      r.size_error = err;
      expected_bytes.push_back(r);
    endfunction

    function void close_frame();
      push_byte(xor_sum, 1'b0, 1'b0);
      push_byte(TrailerByte, 1'b1, 1'b0);
      in_frame   = 1'b0;
      bytes_left = '0;
      xor_sum    = '0;
    endfunction

    function void note_transfer(in_item_t it);
      logic [15:0] total;
      if (it.op == OpStart) begin
        // a start while payload is still owed is ignored outright
        if (in_frame) return;
        if (16'(it.payload_size) > MaxPayload) begin
          push_byte(8'h00, 1'b1, 1'b1);
          return;
        end
        total   = 16'(it.payload_size) + 16'(FrameOverhead);
        xor_sum = it.frame_cmd ^ total[7:0] ^ total[15:8] ^ seq_num;
        push_byte(HeaderByte, 1'b0, 1'b0);
        push_byte(it.frame_cmd, 1'b0, 1'b0);
        push_byte(total[7:0], 1'b0, 1'b0);
        push_byte(total[15:8], 1'b0, 1'b0);
        push_byte(seq_num, 1'b0, 1'b0);
        seq_num = seq_num + 8'd1;
        if (it.payload_size == '0) begin
          close_frame();
        end else begin
          bytes_left = it.payload_size;
          in_frame   = 1'b1;
        end
      end else if (in_frame) begin
        xor_sum = xor_sum ^ it.payload_byte;
        push_byte(it.payload_byte, 1'b0, 1'b0);
        bytes_left = bytes_left - 11'd1;
        if (bytes_left == '0) close_frame();
      end
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte: out_byte %h frame_end %b size_error %b",
               got.out_byte, got.frame_end, got.size_error);
        fails++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        fails++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
        fails++;
      end
      if (got.size_error !== want.size_error) begin
        $error("size_error: expected %b, got %b", want.size_error, got.size_error);
        fails++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  frame_byte_scoreboard sb;
  bit in_quiet;
  bit out_quiet;
  int rx_hold;

  xor_checked_packet_framer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // Output side: check each transfer, then choose ready for the next edge.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_byte(out_item_o);
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else begin
        out_ready_i <= out_quiet || ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic send_item(input in_item_t it);
    while (!in_quiet && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transfer(it);
  endtask

  task automatic send_start(input logic [7:0] cmd, input logic [10:0] size);
    in_item_t it;
    it.op           = OpStart;
    it.frame_cmd    = cmd;
    it.payload_size = size;
    it.payload_byte = 8'($urandom_range(255));
    send_item(it);
  endtask

  task automatic send_payload(input logic [7:0] b);
    in_item_t it;
    it.op           = OpPayload;
    it.frame_cmd    = 8'($urandom_range(255));
    it.payload_size = 11'($urandom_range(2047));
    it.payload_byte = b;
    send_item(it);
  endtask

  // Sender goes quiet until every outstanding byte has been checked or the wait limit is reached.
  task automatic drain_output();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Mostly well-formed frames; some stray payload, oversized starts and
  // starts dropped into the middle of a frame.
  task automatic send_random_frame(inout int n_items);
    int r;
    int size;
    int cut;
    r = $urandom_range(99);
    if (r < 8) begin
      send_payload(8'($urandom_range(255)));
      return;
    end
    if (r < 16) begin
      send_start(8'($urandom_range(255)), 11'($urandom_range(2047, 1025)));
      n_items++;
      return;
    end
    r = $urandom_range(99);
    if (r < 35) size = 0;
    else if (r < 80) size = $urandom_range(6, 1);
    else size = $urandom_range(40, 7);
    cut = ($urandom_range(9) == 0) ? $urandom_range(size) : -1;
    send_start(8'($urandom_range(255)), 11'(size));
    n_items++;
    for (int i = 0; i < size; i++) begin
      if (i == cut) send_start(8'($urandom_range(255)), 11'($urandom_range(2047)));
      send_payload(8'($urandom_range(255)));
      n_items++;
    end
  endtask

  initial begin
    int n_items;
    sb = new();
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    rx_hold   = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: stray payload, empty frames, oversize, ignored start, data
    send_payload(8'hFF);
    send_start(8'h00, 11'd0);
    send_start(8'hFF, 11'd0);
    send_start(8'h3C, 11'd1025);
    send_start(8'hC3, 11'h7FF);
    send_start(8'h5A, 11'd1);
    send_start(8'h11, 11'd3);
    send_payload(8'h00);
    send_start(8'hA5, 11'd3);
    send_payload(8'hFF);
    send_payload(8'h00);
    send_payload(8'h80);
    send_payload(8'h01);
    drain_output();

    n_items = 0;
    while (n_items < 60) begin
      in_quiet  = (n_items >= 20 && n_items < 45);
      out_quiet = in_quiet;
      send_random_frame(n_items);
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;

    // long output stall: empty frames back up into the input; also wraps the
    // sequence number
    rx_hold = 300;
    repeat (256) send_start(8'($urandom_range(255)), 11'd0);

    drain_output();
    repeat (20) @(posedge clk_i);
    if (sb.expected_bytes.size() != 0) begin
      $error("%0d expected output bytes never arrived", sb.expected_bytes.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
